// ----- rtl/point_to_point_velocity_commander_assert.svh -----
// Assertion macros for the point-to-point velocity commander.
`ifndef POINT_TO_POINT_VELOCITY_COMMANDER_ASSERT_SVH
`define POINT_TO_POINT_VELOCITY_COMMANDER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PPVC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppvc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PPVC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppvc: next-cycle check failed");

`endif

// ----- rtl/ppvc_pkg.sv -----
// Package: types and constants of the point-to-point velocity commander.
package ppvc_pkg;

    localparam int POS_W   = 24;
    localparam int VEL_W   = 16;
    localparam int SPD_W   = 15;
    localparam int TOL_W   = 16;
    localparam int TICK_W  = 16;
    localparam int DIFF_W  = POS_W + 1;
    localparam int PROD_W  = SPD_W + DIFF_W;
    localparam int SQ_W    = 2 * TOL_W;
    localparam int DIST_W  = SQ_W + 1;
    localparam int IN_W    = 56;
    localparam int OUT_W   = 40;
    localparam int CFG_W   = 16;

    localparam logic [SPD_W-1:0]  STEP_SPEED_RST = 15'd1000;
    localparam logic [TOL_W-1:0]  TOLERANCE_RST  = 16'd50;
    localparam logic [TICK_W-1:0] TIMEOUT_RST    = 16'd300;

    typedef enum logic [1:0] {
        FN_ODOM    = 2'd0,
        FN_GOAL    = 2'd1,
        FN_TICK    = 2'd2,
        FN_PREEMPT = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_RUNNING   = 2'd0,
        ST_SUCCEEDED = 2'd1,
        ST_TIMEOUT   = 2'd2,
        ST_PREEMPTED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_STEP_SPEED = 2'd0,
        CFG_TOLERANCE  = 2'd1,
        CFG_TIMEOUT    = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MUL,
        S_DIV,
        S_VEL,
        S_STOP
    } state_t;

endpackage

// ----- rtl/point_to_point_velocity_commander.sv -----
// Point-to-point velocity commander: goal tracking, bit-serial velocity and arrival math.
// Odometry, goal, idle-tick and idle-preempt transfers give no result. A preempt of a
// running goal goes to the stop state, which loads its stop result into the output
// register, and the block then takes the next input. A tick of a running goal passes
// through a setup state for the offsets, the shift-add unit (speed times minor offset,
// both squared offsets, squared tolerance side by side) and the restoring divider that
// yields the minor-axis speed, then loads each result into the output register in turn
// (velocity, and a stop result when the goal ends) before the block takes the next input.
// A result waits while the output register still holds an untaken one; the output
// register holds each result until it is taken.
`include "point_to_point_velocity_commander_assert.svh"

module point_to_point_velocity_commander (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [ppvc_pkg::IN_W-1:0] s_axis_tdata,  // pos_x, pos_y, relative, zero pad
    input  logic [1:0]                s_axis_tuser,  // func
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [ppvc_pkg::OUT_W-1:0] m_axis_tdata, // vel_x, vel_y, status, zero pad
    output logic                      m_axis_tlast,  // last
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [ppvc_pkg::CFG_W-1:0] cfg_data
);
    import ppvc_pkg::*;

    state_t state_reg, state_next;

    logic [SPD_W-1:0]  step_speed_reg;
    logic [TOL_W-1:0]  tolerance_reg;
    logic [TICK_W-1:0] timeout_reg;

    logic signed [POS_W-1:0] cur_x_reg, cur_y_reg, tgt_x_reg, tgt_y_reg;
    logic                    moving_reg;
    logic [TICK_W-1:0]       tick_count_reg;

    logic               x_major_reg, x_pos_reg, y_pos_reg, zero_reg, far_reg;
    logic [DIFF_W-1:0]  major_reg;
    logic [SPD_W-1:0]   spd_sh_reg;
    logic [PROD_W-1:0]  mnr_sh_reg, prod_reg;
    logic [SQ_W-1:0]    sqx_a_reg, sqy_a_reg, tol_a_reg, tol2_reg;
    logic [TOL_W-1:0]   sqx_b_reg, sqy_b_reg, tol_b_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [DIFF_W:0]    rem_reg;
    logic [SPD_W-1:0]   div_low_reg, quo_reg;
    logic [3:0]         cnt_reg;
    status_t            fin_reg;

    logic               out_valid_reg, out_last_reg;
    logic [VEL_W-1:0]   out_vx_reg, out_vy_reg;
    status_t            out_st_reg;

    logic               in_xfer, out_free, load_vel, load_stop;
    func_t              func;
    logic [POS_W-1:0]   in_x, in_y;
    logic               in_rel;
    logic [DIFF_W-1:0]  sum_x, sum_y, dx, dy, ax, ay;
    logic [POS_W-1:0]   sat_x, sat_y;
    logic               x_major;
    logic [DIFF_W:0]    div_t;
    logic               div_ge;
    logic [DIST_W-1:0]  dist_next;
    logic               arrive, timed_out;
    logic [VEL_W-1:0]   mag_x, mag_y, vel_x, vel_y;

    assign func   = func_t'(s_axis_tuser);
    assign in_x   = s_axis_tdata[POS_W-1:0];
    assign in_y   = s_axis_tdata[2*POS_W-1:POS_W];
    assign in_rel = s_axis_tdata[2*POS_W];

    assign sum_x = {in_x[POS_W-1], in_x} + {cur_x_reg[POS_W-1], cur_x_reg};
    assign sum_y = {in_y[POS_W-1], in_y} + {cur_y_reg[POS_W-1], cur_y_reg};
    assign sat_x = (sum_x[DIFF_W-1] != sum_x[POS_W-1])
                 ? {sum_x[DIFF_W-1], {(POS_W-1){~sum_x[DIFF_W-1]}}} : sum_x[POS_W-1:0];
    assign sat_y = (sum_y[DIFF_W-1] != sum_y[POS_W-1])
                 ? {sum_y[DIFF_W-1], {(POS_W-1){~sum_y[DIFF_W-1]}}} : sum_y[POS_W-1:0];

    assign dx = {tgt_x_reg[POS_W-1], tgt_x_reg} - {cur_x_reg[POS_W-1], cur_x_reg};
    assign dy = {tgt_y_reg[POS_W-1], tgt_y_reg} - {cur_y_reg[POS_W-1], cur_y_reg};
    assign ax = dx[DIFF_W-1] ? (~dx + 1'b1) : dx;
    assign ay = dy[DIFF_W-1] ? (~dy + 1'b1) : dy;
    assign x_major = ax > ay;

    assign div_t  = {rem_reg[DIFF_W-1:0], div_low_reg[SPD_W-1]};
    assign div_ge = div_t >= {1'b0, major_reg};

    assign dist_next = dist_reg
                     + (sqx_b_reg[0] ? {1'b0, sqx_a_reg} : '0)
                     + (sqy_b_reg[0] ? {1'b0, sqy_a_reg} : '0);

    assign arrive    = !far_reg && (dist_reg < {1'b0, tol2_reg});
    assign timed_out = tick_count_reg >= timeout_reg;

    assign mag_x = {1'b0, (x_major_reg ? step_speed_reg : quo_reg)};
    assign mag_y = {1'b0, (x_major_reg ? quo_reg : step_speed_reg)};
    assign vel_x = zero_reg ? '0 : (x_pos_reg ? mag_x : (~mag_x + 1'b1));
    assign vel_y = zero_reg ? '0 : (y_pos_reg ? mag_y : (~mag_y + 1'b1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && moving_reg && func == FN_TICK)
                begin
                    state_next = S_SETUP;
                end
                else if (in_xfer && moving_reg && func == FN_PREEMPT)
                begin
                    state_next = S_STOP;
                end
            end
            S_SETUP: state_next = S_MUL;
            S_MUL:
            begin
                if (cnt_reg == 4'd15)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == 4'(SPD_W - 1))
                begin
                    state_next = S_VEL;
                end
            end
            S_VEL:
            begin
                if (out_free)
                begin
                    state_next = (fin_reg != ST_RUNNING) ? S_STOP : S_IDLE;
                end
            end
            S_STOP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_axis_tready = (state_reg == S_IDLE);
        in_xfer       = s_axis_tvalid && s_axis_tready;
        out_free      = !out_valid_reg || m_axis_tready;
        load_vel      = (state_reg == S_VEL) && out_free;
        load_stop     = (state_reg == S_STOP) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_speed_reg <= STEP_SPEED_RST;
            tolerance_reg  <= TOLERANCE_RST;
            timeout_reg    <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_STEP_SPEED: step_speed_reg <= cfg_data[SPD_W-1:0];
                CFG_TOLERANCE:  tolerance_reg  <= cfg_data[TOL_W-1:0];
                CFG_TIMEOUT:    timeout_reg    <= cfg_data[TICK_W-1:0];
                CFG_UNUSED:     ;
                default:        ;
            endcase
        end
    end

    // goal state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            tgt_x_reg      <= '0;
            tgt_y_reg      <= '0;
            moving_reg     <= 1'b0;
            tick_count_reg <= '0;
            fin_reg        <= ST_RUNNING;
        end
        else
        begin
            if (in_xfer)
            begin
                unique case (func)
                    FN_ODOM:
                    begin
                        cur_x_reg <= in_x;
                        cur_y_reg <= in_y;
                    end
                    FN_GOAL:
                    begin
                        tgt_x_reg      <= in_rel ? sat_x : in_x;
                        tgt_y_reg      <= in_rel ? sat_y : in_y;
                        tick_count_reg <= '0;
                        moving_reg     <= 1'b1;
                    end
                    FN_PREEMPT: fin_reg <= ST_PREEMPTED;
                    FN_TICK:    ;
                    default:    ;
                endcase
            end
            if (state_reg == S_SETUP && tick_count_reg != '1)
            begin
                tick_count_reg <= tick_count_reg + 1'b1;
            end
            if (state_reg == S_DIV && cnt_reg == 4'(SPD_W - 1))
            begin
                fin_reg <= arrive ? ST_SUCCEEDED : (timed_out ? ST_TIMEOUT : ST_RUNNING);
            end
            if (load_stop)
            begin
                moving_reg <= 1'b0;
            end
        end
    end

    // bit-serial datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_SETUP:
            begin
                x_major_reg <= x_major;
                x_pos_reg   <= !dx[DIFF_W-1] && (dx != '0);
                y_pos_reg   <= !dy[DIFF_W-1] && (dy != '0);
                zero_reg    <= (ax == '0) && (ay == '0);
                far_reg     <= (ax[DIFF_W-1:TOL_W] != '0) || (ay[DIFF_W-1:TOL_W] != '0);
                major_reg   <= x_major ? ax : ay;
                mnr_sh_reg  <= {{SPD_W{1'b0}}, (x_major ? ay : ax)};
                spd_sh_reg  <= step_speed_reg;
                prod_reg    <= '0;
                sqx_a_reg   <= {{TOL_W{1'b0}}, ax[TOL_W-1:0]};
                sqx_b_reg   <= ax[TOL_W-1:0];
                sqy_a_reg   <= {{TOL_W{1'b0}}, ay[TOL_W-1:0]};
                sqy_b_reg   <= ay[TOL_W-1:0];
                tol_a_reg   <= {{TOL_W{1'b0}}, tolerance_reg};
                tol_b_reg   <= tolerance_reg;
                tol2_reg    <= '0;
                dist_reg    <= '0;
                cnt_reg     <= '0;
            end
            S_MUL:
            begin
                prod_reg   <= prod_reg + (spd_sh_reg[0] ? mnr_sh_reg : '0);
                spd_sh_reg <= spd_sh_reg >> 1;
                mnr_sh_reg <= mnr_sh_reg << 1;
                dist_reg   <= dist_next;
                sqx_a_reg  <= sqx_a_reg << 1;
                sqx_b_reg  <= sqx_b_reg >> 1;
                sqy_a_reg  <= sqy_a_reg << 1;
                sqy_b_reg  <= sqy_b_reg >> 1;
                tol2_reg   <= tol2_reg + (tol_b_reg[0] ? tol_a_reg : '0);
                tol_a_reg  <= tol_a_reg << 1;
                tol_b_reg  <= tol_b_reg >> 1;
                if (cnt_reg == 4'd15)
                begin
                    // all speed bits consumed: seed the divider
                    rem_reg     <= {1'b0, prod_reg[PROD_W-1:SPD_W]};
                    div_low_reg <= prod_reg[SPD_W-1:0];
                    quo_reg     <= '0;
                    cnt_reg     <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                rem_reg     <= div_ge ? (div_t - {1'b0, major_reg}) : div_t;
                quo_reg     <= {quo_reg[SPD_W-2:0], div_ge};
                div_low_reg <= div_low_reg << 1;
                cnt_reg     <= cnt_reg + 1'b1;
            end
            S_IDLE, S_VEL, S_STOP: ;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_vel || load_stop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_vel)
        begin
            out_vx_reg   <= vel_x;
            out_vy_reg   <= vel_y;
            out_st_reg   <= ST_RUNNING;
            out_last_reg <= (fin_reg == ST_RUNNING);
        end
        else if (load_stop)
        begin
            out_vx_reg   <= '0;
            out_vy_reg   <= '0;
            out_st_reg   <= fin_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(OUT_W - 2*VEL_W - 2){1'b0}}, out_st_reg, out_vy_reg, out_vx_reg};

    `PPVC_ASSERT_IMP(a_busy_needs_goal,
        (state_reg == S_SETUP || state_reg == S_MUL || state_reg == S_DIV), moving_reg)
    `PPVC_ASSERT_IMP(a_div_rem_bound,
        (state_reg == S_DIV && !zero_reg), (rem_reg < {1'b0, major_reg}))
    `PPVC_ASSERT_IMP(a_stop_is_still,
        (m_axis_tvalid && m_axis_tdata[2*VEL_W+1:2*VEL_W] != ST_RUNNING),
        (m_axis_tdata[2*VEL_W-1:0] == '0 && m_axis_tlast))
    `PPVC_ASSERT_NXT(a_stop_ends_goal, load_stop, (!moving_reg && m_axis_tvalid))

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the point-to-point velocity commander: directed table, then random motion.
module tb_top;
    import ppvc_pkg::*;

    localparam int PERIOD      = 10;
    localparam int SETTLE      = 60;
    localparam int LIMIT_TIME  = 10_000_000;
    localparam int PHASE_ITEMS = 145;
    localparam int NUM_PHASES  = 7;
    localparam int MAX_PRINTS  = 100;
    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        status_t                 status;
        logic                    last;
    } cmd_t;

    typedef struct packed {
        func_t                   func;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic                    rel;
    } stim_t;

    typedef struct {
        func_t func;
        int    px;
        int    py;
        bit    rel;
        bit    typed;
        int    n_cmd;
        cmd_t  c0;
        cmd_t  c1;
    } dir_row_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata  = '0;   // pos_x, pos_y, relative, zero pad
    logic [1:0]          s_axis_tuser  = FN_ODOM; // func
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;         // vel_x, vel_y, status, zero pad
    logic                m_axis_tlast;         // last
    logic                cfg_we        = 1'b0;
    logic [1:0]          cfg_index     = CFG_STEP_SPEED;
    logic [CFG_W-1:0]    cfg_data      = '0;

    // predictor state
    logic [SPD_W-1:0]        spd_cfg  = STEP_SPEED_RST;
    logic [TOL_W-1:0]        tol_cfg  = TOLERANCE_RST;
    logic [TICK_W-1:0]       tmo_cfg  = TIMEOUT_RST;
    logic signed [POS_W-1:0] tgt_x    = '0;
    logic signed [POS_W-1:0] tgt_y    = '0;
    logic signed [POS_W-1:0] cur_x    = '0;
    logic signed [POS_W-1:0] cur_y    = '0;
    bit                      moving   = 1'b0;
    logic [TICK_W-1:0]       tick_cnt = '0;

    cmd_t cmd_q[$];
    int   errors       = 0;
    int   active_items = 0;
    bit   no_idle      = 1'b0;
    int   hold_req     = 0;

    dir_row_t dir_tab [25] = '{
        '{FN_TICK,    0,        0,        1'b0, 1'b1, 0, '0, '0},
        '{FN_PREEMPT, 0,        0,        1'b0, 1'b1, 0, '0, '0},
        '{FN_ODOM,    0,        0,        1'b0, 1'b1, 0, '0, '0},
        '{FN_GOAL,    8388607,  0,        1'b0, 1'b1, 0, '0, '0},
        '{FN_TICK,    0,        0,        1'b0, 1'b1, 1,
          '{16'sd1000, 16'sd0, ST_RUNNING, 1'b1}, '0},
        '{FN_PREEMPT, 0,        0,        1'b0, 1'b1, 1,
          '{16'sd0, 16'sd0, ST_PREEMPTED, 1'b1}, '0},
        '{FN_GOAL,    -8388608, -8388608, 1'b0, 1'b1, 0, '0, '0},
        '{FN_TICK,    0,        0,        1'b0, 1'b1, 1,
          '{-16'sd1000, -16'sd1000, ST_RUNNING, 1'b1}, '0},
        '{FN_ODOM,    -8388608, -8388608, 1'b1, 1'b1, 0, '0, '0},
        '{FN_TICK,    0,        0,        1'b0, 1'b1, 2,
          '{16'sd0, 16'sd0, ST_RUNNING, 1'b0}, '{16'sd0, 16'sd0, ST_SUCCEEDED, 1'b1}},
        '{FN_ODOM,    8388607,  100,      1'b0, 1'b1, 0, '0, '0},
        '{FN_GOAL,    5,        -200,     1'b1, 1'b0, 0, '0, '0},
        '{FN_TICK,    0,        0,        1'b0, 1'b0, 0, '0, '0},
        '{FN_GOAL,    -8388608, 8388607,  1'b1, 1'b0, 0, '0, '0},
        '{FN_TICK,    0,        0,        1'b0, 1'b0, 0, '0, '0},
        '{FN_ODOM,    -8388608, -8388608, 1'b0, 1'b1, 0, '0, '0},
        '{FN_GOAL,    -1,       -8388608, 1'b1, 1'b0, 0, '0, '0},
        '{FN_TICK,    0,        0,        1'b0, 1'b0, 0, '0, '0},
        '{FN_ODOM,    0,        0,        1'b0, 1'b1, 0, '0, '0},
        '{FN_GOAL,    3000,     -1000,    1'b0, 1'b1, 0, '0, '0},
        '{FN_TICK,    0,        0,        1'b0, 1'b0, 0, '0, '0},
        '{FN_GOAL,    -700,     2100,     1'b0, 1'b1, 0, '0, '0},
        '{FN_TICK,    0,        0,        1'b0, 1'b0, 0, '0, '0},
        '{FN_ODOM,    -689,     2100,     1'b0, 1'b1, 0, '0, '0},
        '{FN_TICK,    0,        0,        1'b0, 1'b0, 0, '0, '0}
    };

    point_to_point_velocity_commander dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #(PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(LIMIT_TIME);
        $display("[point_to_point_velocity_commander] ERROR");
        $finish;
    end

    function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
        if (v > longint'(POS_MAX))
            return POS_MAX;
        if (v < longint'(POS_MIN))
            return POS_MIN;
        return POS_W'(v);
    endfunction

    function automatic logic signed [VEL_W-1:0] signed_mag(longint d, longint mag);
        return (d > 0) ? VEL_W'(mag) : VEL_W'(-mag);
    endfunction

    // Updates the tracked goal state and returns the number of commands the item causes.
    function automatic int plan_motion(stim_t it, output cmd_t c0, output cmd_t c1);
        longint  dx, dy, ax, ay, minor, dist2, tol2;
        status_t fin;
        c0 = '0;
        c1 = '0;
        case (it.func)
            FN_ODOM:
            begin
                cur_x = it.px;
                cur_y = it.py;
                return 0;
            end
            FN_GOAL:
            begin
                if (it.rel)
                begin
                    tgt_x = clamp_pos(longint'($signed(it.px)) + longint'(cur_x));
                    tgt_y = clamp_pos(longint'($signed(it.py)) + longint'(cur_y));
                end
                else
                begin
                    tgt_x = it.px;
                    tgt_y = it.py;
                end
                tick_cnt = '0;
                moving   = 1'b1;
                return 0;
            end
            FN_PREEMPT:
            begin
                if (!moving)
                    return 0;
                moving    = 1'b0;
                c0.status = ST_PREEMPTED;
                c0.last   = 1'b1;
                return 1;
            end
            default: ;
        endcase
        if (!moving)
            return 0;
        dx = longint'(tgt_x) - longint'(cur_x);
        dy = longint'(tgt_y) - longint'(cur_y);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax > ay)
        begin
            minor    = (longint'(spd_cfg) * ay) / ax;
            c0.vel_x = signed_mag(dx, longint'(spd_cfg));
            c0.vel_y = signed_mag(dy, minor);
        end
        else if (ay != 0)
        begin
            minor    = (longint'(spd_cfg) * ax) / ay;
            c0.vel_x = signed_mag(dx, minor);
            c0.vel_y = signed_mag(dy, longint'(spd_cfg));
        end
        if (tick_cnt != '1)
            tick_cnt++;
        dist2 = ax * ax + ay * ay;
        tol2  = longint'(tol_cfg) * longint'(tol_cfg);
        fin   = ST_RUNNING;
        if (dist2 < tol2)
            fin = ST_SUCCEEDED;
        else if (tick_cnt >= tmo_cfg)
            fin = ST_TIMEOUT;
        c0.status = ST_RUNNING;
        c0.last   = (fin == ST_RUNNING);
        if (fin == ST_RUNNING)
            return 1;
        moving    = 1'b0;
        c1.status = fin;
        c1.last   = 1'b1;
        return 2;
    endfunction

    function automatic logic signed [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return POS_W'($urandom);
            1: return POS_W'(int'($urandom_range(0, 2000)) - 1000);
            2: return $urandom_range(0, 1) ? POS_MAX : POS_MIN;
            default: return POS_W'(int'($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    function automatic int rand_off(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic report_mismatch(string what, cmd_t got, cmd_t want);
        if (errors < MAX_PRINTS)
            $display("%0t: %s: got %0d %0d st=%0d last=%0b, want %0d %0d st=%0d last=%0b",
                     $time, what, got.vel_x, got.vel_y, got.status, got.last,
                     want.vel_x, want.vel_y, want.status, want.last);
        errors++;
    endtask

    task automatic send_item(stim_t it, bit use_typed = 1'b0, int n_typed = 0,
                             cmd_t typed0 = '0, cmd_t typed1 = '0);
        int   gap;
        int   n;
        cmd_t c0, c1;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.func;
        s_axis_tdata  <= {{(IN_W - 2 * POS_W - 1){1'b0}}, it.rel, it.py, it.px};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        active_items++;
        n = plan_motion(it, c0, c1);
        if (use_typed)
        begin
            n  = n_typed;
            c0 = typed0;
            c1 = typed1;
        end
        if (n > 0)
            cmd_q.push_back(c0);
        if (n > 1)
            cmd_q.push_back(c1);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (cmd_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_STEP_SPEED: spd_cfg = val[SPD_W-1:0];
            CFG_TOLERANCE:  tol_cfg = val;
            CFG_TIMEOUT:    tmo_cfg = val;
            default: ;
        endcase
    endtask

    // odometry, goal, then ticks with the robot drifting toward the target
    task automatic run_episode();
        stim_t it;
        int    span;
        int    jit;
        span    = int'(tol_cfg) * 3 + 20;
        jit     = int'(tol_cfg) + 5;
        it.func = FN_ODOM;
        it.px   = rand_pos();
        it.py   = rand_pos();
        it.rel  = 1'($urandom_range(0, 1));
        send_item(it);
        it.func = FN_GOAL;
        it.rel  = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
        begin
            it.px = rand_pos();
            it.py = rand_pos();
        end
        else if (it.rel)
        begin
            it.px = POS_W'(rand_off(span));
            it.py = POS_W'(rand_off(span));
        end
        else
        begin
            it.px = clamp_pos(longint'(cur_x) + rand_off(span));
            it.py = clamp_pos(longint'(cur_y) + rand_off(span));
        end
        send_item(it);
        repeat ($urandom_range(1, 10))
        begin
            case ($urandom_range(0, 15))
                0, 1, 2:
                begin
                    it.func = FN_ODOM;
                    it.px   = clamp_pos(longint'(tgt_x) + rand_off(jit));
                    it.py   = clamp_pos(longint'(tgt_y) + rand_off(jit));
                    send_item(it);
                end
                3, 4:
                begin
                    it.func = FN_ODOM;
                    it.px   = clamp_pos((longint'(cur_x) + longint'(tgt_x)) / 2);
                    it.py   = clamp_pos((longint'(cur_y) + longint'(tgt_y)) / 2);
                    send_item(it);
                end
                5:
                begin
                    it.func = FN_PREEMPT;
                    it.px   = POS_W'($urandom);
                    send_item(it);
                end
                6:
                begin
                    it.func = FN_GOAL;
                    it.rel  = 1'b1;
                    it.px   = POS_W'(rand_off(span));
                    it.py   = POS_W'(rand_off(span));
                    send_item(it);
                end
                7:
                begin
                    it.func = func_t'($urandom_range(0, 3));
                    it.px   = POS_W'($urandom);
                    it.py   = POS_W'($urandom);
                    it.rel  = 1'($urandom_range(0, 1));
                    send_item(it);
                end
                default: ;
            endcase
            it.func = FN_TICK;
            it.px   = POS_W'($urandom);
            it.py   = POS_W'($urandom);
            it.rel  = 1'($urandom_range(0, 1));
            send_item(it);
        end
    endtask

    // result sink with random back-pressure and an occasional long hold-off
    initial
    begin
        int stall;
        int nh;
        @(posedge rst_n);
        forever
        begin
            if (hold_req > 0)
            begin
                nh       = hold_req;
                hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (nh) @(posedge clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_cmd
        cmd_t got;
        cmd_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.vel_x  = m_axis_tdata[VEL_W-1:0];
            got.vel_y  = m_axis_tdata[2*VEL_W-1:VEL_W];
            got.status = status_t'(m_axis_tdata[2*VEL_W+1:2*VEL_W]);
            got.last   = m_axis_tlast;
            if (cmd_q.size() == 0)
                report_mismatch("transfer with nothing pending", got, got);
            else
            begin
                want = cmd_q.pop_front();
                if (got.vel_x !== want.vel_x)
                    report_mismatch("vel_x", got, want);
                if (got.vel_y !== want.vel_y)
                    report_mismatch("vel_y", got, want);
                if (got.status !== want.status)
                    report_mismatch("status", got, want);
                if (got.last !== want.last)
                    report_mismatch("last", got, want);
            end
        end
    end

    initial
    begin
        stim_t it;
        int    goal_cnt;
        bit    paused;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            it.func = dir_tab[i].func;
            it.px   = POS_W'(dir_tab[i].px);
            it.py   = POS_W'(dir_tab[i].py);
            it.rel  = dir_tab[i].rel;
            send_item(it, dir_tab[i].typed, dir_tab[i].n_cmd, dir_tab[i].c0, dir_tab[i].c1);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            no_idle = (p == 0);
            case (p)
                0:
                begin
                    write_reg(CFG_STEP_SPEED, 16'hFFFF);
                    write_reg(CFG_TOLERANCE, 16'hFFFF);
                    write_reg(CFG_TIMEOUT, 16'hFFFF);
                end
                1:
                begin
                    write_reg(CFG_STEP_SPEED, 16'd0);
                    write_reg(CFG_TOLERANCE, 16'd0);
                    write_reg(CFG_TIMEOUT, 16'd1);
                end
                2:
                begin
                    write_reg(CFG_STEP_SPEED, 16'd1234);
                    write_reg(CFG_TOLERANCE, 16'd200);
                    write_reg(CFG_TIMEOUT, 16'd0);
                    write_reg(CFG_UNUSED, CFG_W'($urandom));
                end
                3:
                begin
                    write_reg(CFG_STEP_SPEED, CFG_W'($urandom));
                    write_reg(CFG_TOLERANCE, CFG_W'($urandom_range(0, 300)));
                    write_reg(CFG_TIMEOUT, CFG_W'($urandom_range(1, 6)));
                end
                4:
                begin
                    write_reg(CFG_STEP_SPEED, CFG_W'($urandom));
                    write_reg(CFG_TOLERANCE, CFG_W'($urandom_range(0, 1000)));
                    write_reg(CFG_TIMEOUT, CFG_W'($urandom_range(1, 20)));
                end
                5:
                begin
                    write_reg(CFG_STEP_SPEED, 16'd1000);
                    write_reg(CFG_TOLERANCE, 16'd50);
                    write_reg(CFG_TIMEOUT, 16'd4);
                end
                default:
                begin
                    write_reg(CFG_STEP_SPEED, CFG_W'($urandom));
                    write_reg(CFG_TOLERANCE, CFG_W'($urandom));
                    write_reg(CFG_TIMEOUT, CFG_W'($urandom_range(1, 12)));
                    write_reg(CFG_UNUSED, CFG_W'($urandom));
                end
            endcase
            cfg_we <= 1'b0;
            if (p == 5)
                hold_req = 400;
            goal_cnt = active_items + PHASE_ITEMS;
            paused   = 1'b0;
            while (active_items < goal_cnt)
            begin
                run_episode();
                // sender pause until the sink has drained
                if (p == 3 && !paused && active_items >= goal_cnt - PHASE_ITEMS / 2)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
        end

        wait_idle();
        if (errors == 0)
            $display("[point_to_point_velocity_commander] OK");
        else
            $display("[point_to_point_velocity_commander] ERROR");
        $finish;
    end

endmodule
